// File: rtl/wfft_pkg.sv
// ----------------------------------------------------------------------------
// wfft_pkg
// Shared constants, widths and the cosine table function of the windowed FFT.
// ----------------------------------------------------------------------------
`default_nettype none

package wfft_pkg;

  localparam int POINTS  = 1024;
  localparam int LG      = $clog2(POINTS);
  localparam int ADDR_W  = LG;
  localparam int CNT_W   = LG + 1;
  localparam int STG_W   = $clog2(LG + 1);
  localparam int QTR     = POINTS / 4;
  localparam int DATA_W  = 27;
  localparam int SMP_W   = 16;
  localparam int COS_W   = 16;
  localparam int REC_W   = 33;
  localparam int PH_W    = 32;
  localparam int WACC_W  = 38;
  localparam int WPROD_W = SMP_W + WACC_W;
  localparam int BPROD_W = DATA_W + COS_W;
  localparam int T_W     = BPROD_W + 1 - 15;
  localparam int SUM_W   = T_W + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // window coefficients in Q20, a0 pre-scaled to Q35
  localparam logic signed [WACC_W-1:0] WIN_A0S = 38'sd381243 * 38'sd32768;
  localparam logic signed [WACC_W-1:0] WIN_A1  = 38'sd512940;
  localparam logic signed [WACC_W-1:0] WIN_A2  = 38'sd143235;
  localparam logic signed [WACC_W-1:0] WIN_A3  = 38'sd11158;

  localparam logic signed [DATA_W-1:0] OUT_MAX = 27'sd67108863;
  localparam logic signed [DATA_W-1:0] OUT_MIN = -27'sd67108864;

  // sin(pi/2 * r/QTR) in Q1.15 by a Taylor series in Q30
  function automatic logic signed [COS_W-1:0] quarter_sine(input int unsigned r);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (HALF_PI_Q30 * 64'(r)) / QTR;
    term = x;
    sum  = longint'(x);
    term = (((term * x) >> 30) * x) >> 30; term = term / 6;   sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 20;  sum = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 42;  sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 72;  sum = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 110; sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 156; sum = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 210; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    v = (sum + 16384) >>> 15;
    if (v > 32767) v = 32767;
    return COS_W'(v);
  endfunction

  // cos(2*pi*m/POINTS) in Q1.15
  function automatic logic signed [COS_W-1:0] cos_val(input logic [ADDR_W-1:0] m);
    logic [1:0]  quad;
    int unsigned r;
    logic signed [COS_W-1:0] v;
    quad = m[ADDR_W-1:ADDR_W-2];
    r    = int'(m[ADDR_W-3:0]);
    case (quad)
      2'd0:    v = quarter_sine(QTR - r);
      2'd1:    v = -quarter_sine(r);
      2'd2:    v = -quarter_sine(QTR - r);
      default: v = quarter_sine(r);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/windowed_radix2_fft.sv
// ----------------------------------------------------------------------------
// windowed_radix2_fft
// Windowed in-place radix-2 DIT FFT over one shared complex work memory.
// ----------------------------------------------------------------------------
// Load requests are taken back to back while idle and no result waits. Bin read: the
// word is read from the work memory into a register, then the result registers are set.
// Transform after the last sample: the reciprocal divider, windowing of each received
// sample, zero padding, bit-reversal swaps, then POINTS/2 * log2(POINTS) butterflies;
// the shared work memory takes one read and one write a cycle.
// Reset clears control state and frame status; the work memory is not cleared.
`default_nettype none

module windowed_radix2_fft (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        cmd,
  input  wire logic signed [15:0]          sample,
  input  wire logic                        last,
  input  wire logic [9:0]                  bin_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [26:0]               bin_real,
  output logic signed [26:0]               bin_imag,
  output logic                             status
);

  localparam int AW  = wfft_pkg::ADDR_W;
  localparam int CW  = wfft_pkg::CNT_W;
  localparam int DW  = wfft_pkg::DATA_W;
  localparam int LG  = wfft_pkg::LG;
  localparam int SW  = wfft_pkg::STG_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_READ = 5'd1;
  localparam logic [4:0] S_DIV  = 5'd2;
  localparam logic [4:0] S_WIN0 = 5'd3;
  localparam logic [4:0] S_WIN1 = 5'd4;
  localparam logic [4:0] S_WIN2 = 5'd5;
  localparam logic [4:0] S_WIN3 = 5'd6;
  localparam logic [4:0] S_WIN4 = 5'd7;
  localparam logic [4:0] S_WIN5 = 5'd8;
  localparam logic [4:0] S_PAD  = 5'd9;
  localparam logic [4:0] S_REV0 = 5'd10;
  localparam logic [4:0] S_REV1 = 5'd11;
  localparam logic [4:0] S_REV2 = 5'd12;
  localparam logic [4:0] S_REV3 = 5'd13;
  localparam logic [4:0] S_BF0  = 5'd14;
  localparam logic [4:0] S_BF1  = 5'd15;
  localparam logic [4:0] S_BF2  = 5'd16;
  localparam logic [4:0] S_BF3  = 5'd17;
  localparam logic [4:0] S_BF4  = 5'd18;
  localparam logic [4:0] S_BF5  = 5'd19;
  localparam logic [4:0] S_BF6  = 5'd20;
  localparam logic [4:0] S_DONE = 5'd21;

  // helpers
  function automatic logic [AW-1:0] win_idx(input logic [wfft_pkg::PH_W-1:0] ph);
    logic [wfft_pkg::PH_W-1:0] s;
    s = ph + (wfft_pkg::PH_W'(1) << (31 - LG));
    return s[wfft_pkg::PH_W-1 -: AW];
  endfunction

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int k = 0; k < AW; k++) r[k] = v[AW-1-k];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat(input logic signed [wfft_pkg::SUM_W-1:0] v);
    logic signed [DW-1:0] r;
    if (v > wfft_pkg::SUM_W'(wfft_pkg::OUT_MAX)) r = wfft_pkg::OUT_MAX;
    else if (v < wfft_pkg::SUM_W'(wfft_pkg::OUT_MIN)) r = wfft_pkg::OUT_MIN;
    else r = DW'(v);
    return r;
  endfunction

  logic [4:0]                              state;
  logic [CW-1:0]                           cnt;
  logic [CW-1:0]                           frame_len;
  logic                                    frame_done;
  logic [CW-1:0]                           idx;
  logic [SW-1:0]                           stage;
  logic [wfft_pkg::PH_W-1:0]               recip;
  logic [wfft_pkg::PH_W-1:0]               ph1;
  logic signed [wfft_pkg::SMP_W-1:0]       smp;
  logic signed [wfft_pkg::WACC_W-1:0]      wacc;
  logic signed [wfft_pkg::WPROD_W-1:0]     wprod;
  logic [2*DW-1:0]                         hold;
  logic signed [DW-1:0]                    br, bi, ur, ui;
  logic signed [wfft_pkg::COS_W-1:0]       wr, wi;
  logic signed [wfft_pkg::BPROD_W-1:0]     p1, p2, p3, p4;
  logic signed [wfft_pkg::T_W-1:0]         tr, ti;

  logic                                    accept;
  logic [CW-1:0]                           cnt_new;
  logic                                    div_start;
  logic                                    div_done;
  logic [wfft_pkg::REC_W-1:0]              div_quot;

  logic [2*DW-1:0]                         work_mem [wfft_pkg::POINTS];
  logic [2*DW-1:0]                         rd_data;
  logic [AW-1:0]                           rd_addr;
  logic                                    wr_en;
  logic [AW-1:0]                           wr_addr;
  logic [2*DW-1:0]                         wr_data;

  logic [AW-1:0]                           rom_addr;
  logic signed [wfft_pkg::COS_W-1:0]       rom_data;

  logic [AW-1:0]                           ia, ja, n_ext, half_v, jv, a_addr, b_addr, m_addr;
  logic [wfft_pkg::PH_W-1:0]               ph2, ph3;
  logic signed [wfft_pkg::WPROD_W-1:0]     wround;
  logic signed [wfft_pkg::BPROD_W:0]       tr_full, ti_full;
  logic signed [wfft_pkg::SUM_W-1:0]       sum_r, sum_i, dif_r, dif_i;

  // request handshake
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;
  assign cnt_new  = cnt + CW'(!cnt[CW-1]);
  assign div_start = accept && !cmd && last && (cnt_new != '0);

  // address generation
  assign ia     = idx[AW-1:0];
  assign ja     = bitrev(ia);
  assign n_ext  = {1'b0, idx[AW-2:0]};
  assign half_v = AW'(1) << stage;
  assign jv     = n_ext & (half_v - AW'(1));
  assign a_addr = ((n_ext >> stage) << (stage + SW'(1))) | jv;
  assign b_addr = a_addr | half_v;
  assign m_addr = jv << (SW'(LG - 1) - stage);
  assign ph2    = ph1 << 1;
  assign ph3    = ph1 + ph2;

  // arithmetic
  assign wround  = (wprod + (wfft_pkg::WPROD_W'(1) <<< 34)) >>> 35;
  assign tr_full = ((wfft_pkg::BPROD_W+1)'(p1) - (wfft_pkg::BPROD_W+1)'(p2)
                    + (wfft_pkg::BPROD_W+1)'(16384)) >>> 15;
  assign ti_full = ((wfft_pkg::BPROD_W+1)'(p3) + (wfft_pkg::BPROD_W+1)'(p4)
                    + (wfft_pkg::BPROD_W+1)'(16384)) >>> 15;
  assign sum_r   = wfft_pkg::SUM_W'(ur) + wfft_pkg::SUM_W'(tr);
  assign sum_i   = wfft_pkg::SUM_W'(ui) + wfft_pkg::SUM_W'(ti);
  assign dif_r   = wfft_pkg::SUM_W'(ur) - wfft_pkg::SUM_W'(tr);
  assign dif_i   = wfft_pkg::SUM_W'(ui) - wfft_pkg::SUM_W'(ti);

  // memory port and table address selection
  always_comb begin
    rd_addr  = ia;
    rom_addr = m_addr;
    wr_en    = 1'b0;
    wr_addr  = ia;
    wr_data  = '0;
    case (state)
      S_IDLE: begin
        rd_addr = AW'(bin_index);
        wr_addr = cnt[AW-1:0];
        wr_data = {DW'(sample), DW'(0)};
        wr_en   = accept && !cmd && !cnt[CW-1];
      end
      S_WIN0: rom_addr = win_idx(ph1);
      S_WIN1: rom_addr = win_idx(ph2);
      S_WIN2: rom_addr = win_idx(ph3);
      S_WIN5: begin
        wr_en   = 1'b1;
        wr_data = {DW'(wround), DW'(0)};
      end
      S_PAD: wr_en = !idx[CW-1];
      S_REV1: rd_addr = ja;
      S_REV2: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_REV3: begin
        wr_en   = 1'b1;
        wr_addr = ja;
        wr_data = hold;
      end
      S_BF0: rd_addr = b_addr;
      S_BF1: begin
        rd_addr  = a_addr;
        rom_addr = m_addr - AW'(wfft_pkg::QTR);
      end
      S_BF5: begin
        wr_en   = 1'b1;
        wr_addr = a_addr;
        wr_data = {sat(sum_r), sat(sum_i)};
      end
      S_BF6: begin
        wr_en   = 1'b1;
        wr_addr = b_addr;
        wr_data = {sat(dif_r), sat(dif_i)};
      end
      default: ;
    endcase
  end

  // complex work memory
  always_ff @(posedge clk) begin
    if (wr_en) work_mem[wr_addr] <= wr_data;
    rd_data <= work_mem[rd_addr];
  end

  wfft_cos_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  wfft_recip_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (cnt_new),
    .done    (div_done),
    .quot    (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      frame_done <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd) begin
              state <= S_READ;
            end else if (last) begin
              frame_len <= cnt_new;
              cnt       <= '0;
              idx       <= '0;
              state     <= (cnt_new == '0) ? S_PAD : S_DIV;
            end else begin
              cnt <= cnt_new;
            end
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          status    <= !frame_done;
          bin_real  <= frame_done ? $signed(rd_data[2*DW-1:DW]) : '0;
          bin_imag  <= frame_done ? $signed(rd_data[DW-1:0]) : '0;
          state     <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            recip <= div_quot[wfft_pkg::PH_W-1:0];
            ph1   <= '0;
            state <= S_WIN0;
          end
        end
        S_WIN0: state <= S_WIN1;
        S_WIN1: begin
          smp   <= $signed(rd_data[DW+wfft_pkg::SMP_W-1:DW]);
          wacc  <= wfft_pkg::WIN_A0S - wfft_pkg::WIN_A1 * wfft_pkg::WACC_W'(rom_data);
          state <= S_WIN2;
        end
        S_WIN2: begin
          wacc  <= wacc + wfft_pkg::WIN_A2 * wfft_pkg::WACC_W'(rom_data);
          state <= S_WIN3;
        end
        S_WIN3: begin
          wacc  <= wacc - wfft_pkg::WIN_A3 * wfft_pkg::WACC_W'(rom_data);
          state <= S_WIN4;
        end
        S_WIN4: begin
          wprod <= wfft_pkg::WPROD_W'(smp) * wfft_pkg::WPROD_W'(wacc);
          state <= S_WIN5;
        end
        S_WIN5: begin
          idx   <= idx + CW'(1);
          ph1   <= ph1 + recip;
          state <= (idx + CW'(1) == frame_len) ? S_PAD : S_WIN0;
        end
        S_PAD: begin
          if (idx[CW-1]) begin
            idx   <= '0;
            state <= S_REV0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_REV0: begin
          if (ia < ja) begin
            state <= S_REV1;
          end else if (ia == '1) begin
            idx   <= '0;
            stage <= '0;
            state <= S_BF0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_REV1: begin
          hold  <= rd_data;
          state <= S_REV2;
        end
        S_REV2: state <= S_REV3;
        S_REV3: begin
          idx   <= idx + CW'(1);
          state <= S_REV0;
        end
        S_BF0: state <= S_BF1;
        S_BF1: begin
          br    <= $signed(rd_data[2*DW-1:DW]);
          bi    <= $signed(rd_data[DW-1:0]);
          wr    <= rom_data;
          state <= S_BF2;
        end
        S_BF2: begin
          ur    <= $signed(rd_data[2*DW-1:DW]);
          ui    <= $signed(rd_data[DW-1:0]);
          wi    <= -rom_data;
          state <= S_BF3;
        end
        S_BF3: begin
          p1    <= wfft_pkg::BPROD_W'(br) * wfft_pkg::BPROD_W'(wr);
          p2    <= wfft_pkg::BPROD_W'(bi) * wfft_pkg::BPROD_W'(wi);
          p3    <= wfft_pkg::BPROD_W'(br) * wfft_pkg::BPROD_W'(wi);
          p4    <= wfft_pkg::BPROD_W'(bi) * wfft_pkg::BPROD_W'(wr);
          state <= S_BF4;
        end
        S_BF4: begin
          tr    <= wfft_pkg::T_W'(tr_full);
          ti    <= wfft_pkg::T_W'(ti_full);
          state <= S_BF5;
        end
        S_BF5: state <= S_BF6;
        S_BF6: begin
          state <= S_BF0;
          if (idx[AW-2:0] == '1) begin
            idx <= '0;
            if (stage == SW'(LG - 1)) state <= S_DONE;
            else stage <= stage + SW'(1);
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DONE: begin
          frame_done <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/wfft_cos_rom.sv
// ----------------------------------------------------------------------------
// wfft_cos_rom
// Full-wave cosine table with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wfft_cos_rom (
  input  wire logic                               clk,
  input  wire logic [wfft_pkg::ADDR_W-1:0]        addr,
  output logic signed [wfft_pkg::COS_W-1:0]       data
);

  logic signed [wfft_pkg::COS_W-1:0] rom [wfft_pkg::POINTS];

  // table contents fixed at elaboration
  initial begin
    for (int m = 0; m < wfft_pkg::POINTS; m++) begin
      rom[m] = wfft_pkg::cos_val(wfft_pkg::ADDR_W'(m));
    end
  end

  // registered table lookup
  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

`default_nettype wire

// File: rtl/wfft_recip_div.sv
// ----------------------------------------------------------------------------
// wfft_recip_div
// Bit-serial restoring divider: round(2^32 / count), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wfft_recip_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [wfft_pkg::CNT_W-1:0]    divisor,
  output logic                               done,
  output logic [wfft_pkg::REC_W-1:0]         quot
);

  localparam int BIT_W = $clog2(wfft_pkg::REC_W);

  logic                           run;
  logic [BIT_W-1:0]               bitn;
  logic [wfft_pkg::REC_W-1:0]     num;
  logic [wfft_pkg::CNT_W-1:0]     den;
  logic [wfft_pkg::CNT_W:0]       rem;
  logic [wfft_pkg::CNT_W:0]       rem_sh;
  logic                           ge;

  // trial subtract
  assign rem_sh = {rem[wfft_pkg::CNT_W-1:0], num[wfft_pkg::REC_W-1]};
  assign ge     = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        bitn <= BIT_W'(wfft_pkg::REC_W - 1);
        // numerator 2^32 + count/2 for round to nearest
        num  <= {1'b1, (wfft_pkg::REC_W-1)'(divisor >> 1)};
        den  <= divisor;
        rem  <= '0;
      end else if (run) begin
        rem  <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        quot <= {quot[wfft_pkg::REC_W-2:0], ge};
        num  <= {num[wfft_pkg::REC_W-2:0], 1'b0};
        bitn <= bitn - 1'b1;
        if (bitn == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/wfft_checker.sv
// ----------------------------------------------------------------------------
// wfft_checker
// Port-level checks of the windowed FFT, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfft_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               cmd,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [26:0] bin_real,
  input wire logic signed [26:0] bin_imag,
  input wire logic               status
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bin_real) && $stable(bin_imag)
      && $stable(status))
    else $error("stalled result changed");

  // no-frame status carries zero data
  a_nodata: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> bin_real == 27'sd0 && bin_imag == 27'sd0)
    else $error("status set with nonzero bin");

  // a read request returns its bin on out_valid
  a_read: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd |=> ##1 out_valid)
    else $error("read request gave no result");

  // no new request is taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken with pending result");

endmodule

bind windowed_radix2_fft wfft_checker u_wfft_checker (.*);

`default_nettype wire
